// ===== hdl/pwe_pkg.sv =====
// Shared types, constants and helpers for the printable word extractor.
// Used by the channel interfaces and every module of the block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pwe_pkg;

  // Field widths
  localparam int OFFSET_BITS    = 25;
  localparam int LENGTH_BITS    = 16;
  localparam int RUN_BITS       = LENGTH_BITS + 1;
  localparam int CFG_DATA_BITS  = (OFFSET_BITS > LENGTH_BITS) ? OFFSET_BITS : LENGTH_BITS;
  localparam int CFG_INDEX_BITS = 2;

  // Event queue between scanner and result stage
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [LENGTH_BITS-1:0] length_t;
  typedef logic [RUN_BITS-1:0]    run_t;
  typedef logic [7:0]             char_t;

  // Register map
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MIN_LEN   = 2'd0,
    REG_MAX_LEN   = 2'd1,
    REG_STRINGS   = 2'd2,
    REG_PAGE_SIZE = 2'd3
  } cfg_reg_t;

  // Register reset values
  localparam length_t MIN_LEN_RESET   = LENGTH_BITS'(6);
  localparam length_t MAX_LEN_RESET   = LENGTH_BITS'(14);
  localparam offset_t PAGE_SIZE_RESET = OFFSET_BITS'(64'd16777216);

  // Character codes
  localparam char_t CHAR_SPACE  = 8'h20;
  localparam char_t CHAR_DEL    = 8'h7F;
  localparam char_t CHAR_LPAREN = 8'h28;
  localparam char_t CHAR_RPAREN = 8'h29;
  localparam char_t CHAR_LANGLE = 8'h3C;
  localparam char_t CHAR_RANGLE = 8'h3E;
  localparam char_t CHAR_LBRACK = 8'h5B;
  localparam char_t CHAR_RBRACK = 8'h5D;

  typedef struct packed {
    length_t min_len;
    length_t max_len;
    logic    strings;
    offset_t page_size;
  } cfg_t;

  // One closed word that passed the length filter
  typedef struct packed {
    offset_t ofs;
    length_t len;
    logic    bracket;
  } word_ev_t;

  function automatic logic is_word_char(input char_t c, input logic strings);
    logic r;
    if (c == CHAR_SPACE) r = strings;
    else                 r = (c > CHAR_SPACE) && (c < CHAR_DEL);
    return r;
  endfunction

  function automatic logic is_bracketed(input char_t a, input char_t b);
    return ((a == CHAR_LPAREN) && (b == CHAR_RPAREN)) ||
           ((a == CHAR_LANGLE) && (b == CHAR_RANGLE)) ||
           ((a == CHAR_LBRACK) && (b == CHAR_RBRACK));
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pwe_if.sv =====
// Valid/ready channel interfaces: input bytes, result spans, register writes.
// Depends on pwe_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pwe_in_if import pwe_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t data_byte;
  logic  buffer_start;
  modport source (output valid, data_byte, buffer_start, input ready);
  modport sink   (input valid, data_byte, buffer_start, output ready);
endinterface

interface pwe_out_if import pwe_pkg::*; ();
  logic    valid;
  logic    ready;
  offset_t word_offset;
  length_t word_length;
  logic    is_inner;
  logic    last_of_run;
  modport source (output valid, word_offset, word_length, is_inner, last_of_run,
                  input ready);
  modport sink   (input valid, word_offset, word_length, is_inner, last_of_run,
                  output ready);
endinterface

interface pwe_cfg_if import pwe_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/pwe_front.sv =====
// Scanner front end: accepts one byte per transfer, tracks the open word and
// emits a word event when a word that passes the length filter closes.
// Depends on pwe_pkg and pwe_if.
`timescale 1ns / 1ps
`default_nettype none

module pwe_front
  import pwe_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cfg_t     cfg,
  pwe_in_if.sink        in_chan,
  input  wire logic     queue_full,
  output logic          ev_push,
  output word_ev_t      ev
);

  offset_t idx_r,    idx_nxt;
  logic    inside_r, inside_nxt;
  offset_t start_r,  start_nxt;
  run_t    run_r,    run_nxt;
  char_t   first_r,  first_nxt;
  char_t   prev_r,   prev_nxt;
  logic    stop_r,   stop_nxt;
  logic    ev_valid;
  logic    accept;

  // Take a byte whenever the event queue has room
  assign in_chan.ready = !queue_full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign ev_push       = accept && ev_valid;

  // Scan step: buffer start clears state before the byte is looked at
  always_comb begin
    logic  wb;
    char_t c;
    c = in_chan.data_byte;
    wb = is_word_char(c, cfg.strings);
    if (in_chan.buffer_start) begin
      idx_nxt    = '0;
      inside_nxt = 1'b0;
      start_nxt  = '0;
      run_nxt    = '0;
      first_nxt  = '0;
      prev_nxt   = '0;
      stop_nxt   = 1'b0;
    end else begin
      idx_nxt    = idx_r;
      inside_nxt = inside_r;
      start_nxt  = start_r;
      run_nxt    = run_r;
      first_nxt  = first_r;
      prev_nxt   = prev_r;
      stop_nxt   = stop_r;
    end
    ev_valid   = 1'b0;
    ev.ofs     = start_nxt;
    ev.len     = run_nxt[LENGTH_BITS-1:0];
    ev.bracket = 1'b0;

    if (!stop_nxt) begin
      if (!inside_nxt) begin
        if (wb) begin
          inside_nxt = 1'b1;
          start_nxt  = idx_nxt;
          run_nxt    = RUN_BITS'(1);
          first_nxt  = c;
          prev_nxt   = c;
        end
        // Past the page limit outside a word: halt until next buffer
        if (idx_nxt > cfg.page_size) stop_nxt = 1'b1;
      end else if (wb) begin
        if (run_nxt != '1) run_nxt = run_nxt + 1'b1;
        prev_nxt = c;
      end else begin
        // Word closes: report it if its length is in range
        if (({1'b0, cfg.min_len} <= run_nxt) && (run_nxt <= {1'b0, cfg.max_len})) begin
          ev_valid   = 1'b1;
          ev.bracket = (run_nxt > RUN_BITS'(2)) && is_bracketed(first_nxt, prev_nxt);
        end
        inside_nxt = 1'b0;
        start_nxt  = '0;
        run_nxt    = '0;
      end
      if (!stop_nxt && (idx_nxt != '1)) idx_nxt = idx_nxt + 1'b1;
    end
  end

  // Advance scan state on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      inside_r <= 1'b0;
      start_r  <= '0;
      run_r    <= '0;
      first_r  <= '0;
      prev_r   <= '0;
      stop_r   <= 1'b0;
    end else if (accept) begin
      idx_r    <= idx_nxt;
      inside_r <= inside_nxt;
      start_r  <= start_nxt;
      run_r    <= run_nxt;
      first_r  <= first_nxt;
      prev_r   <= prev_nxt;
      stop_r   <= stop_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pwe_queue.sv =====
// Short event queue between the scanner and the result stage.
// Depends on pwe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwe_queue
  import pwe_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire word_ev_t push_data,
  input  wire logic     pop,
  output word_ev_t      head,
  output logic          empty,
  output logic          full
);

  word_ev_t               slot_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_BITS-1:0]   count_r;
  logic                   do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == QCNT_BITS'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  // Store pushed events
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pwe_back.sv =====
// Result stage: expands each word event into the whole-word result and, for
// bracketed words, the inner span; drives the registered result channel.
// Depends on pwe_pkg and pwe_if.
`timescale 1ns / 1ps
`default_nettype none

module pwe_back
  import pwe_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire word_ev_t head,
  input  wire logic     empty,
  output logic          pop,
  pwe_out_if.source     out_chan
);

  logic    out_valid_r;
  offset_t out_ofs_r;
  length_t out_len_r;
  logic    out_inner_r;
  logic    out_last_r;
  logic    pend_r;
  offset_t pend_ofs_r;
  length_t pend_len_r;
  logic    load;

  assign out_chan.valid       = out_valid_r;
  assign out_chan.word_offset = out_ofs_r;
  assign out_chan.word_length = out_len_r;
  assign out_chan.is_inner    = out_inner_r;
  assign out_chan.last_of_run = out_last_r;

  // Output register is free when empty or being transferred
  assign load = !out_valid_r || out_chan.ready;
  assign pop  = load && !pend_r && !empty;

  // Control: valid and pending inner span
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else if (load) begin
      if (pend_r) begin
        out_valid_r <= 1'b1;
        pend_r      <= 1'b0;
      end else if (!empty) begin
        out_valid_r <= 1'b1;
        pend_r      <= head.bracket;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: whole word first, inner span next
  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_r) begin
        out_ofs_r   <= pend_ofs_r;
        out_len_r   <= pend_len_r;
        out_inner_r <= 1'b1;
        out_last_r  <= 1'b1;
      end else if (!empty) begin
        out_ofs_r   <= head.ofs;
        out_len_r   <= head.len;
        out_inner_r <= 1'b0;
        out_last_r  <= !head.bracket;
        pend_ofs_r  <= head.ofs + 1'b1;
        pend_len_r  <= head.len - LENGTH_BITS'(2);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/printable_word_extractor.sv =====
// Printable word extractor, top level.
// Channels (valid/ready, transfer when both high at a rising edge of clk):
//   in_chan  : one buffer byte per transfer, buffer_start marks byte 0.
//   out_chan : one span per transfer: offset, length, is_inner, last_of_run.
//   cfg_chan : register writes (index 0 min length, 1 max length,
//              2 strings mode, 3 page size); always ready.
// Throughput: one input byte per cycle while the event queue has room. A byte
//   that closes a bracketed word yields two results, the whole word and its
//   inner span; a four-entry event queue between scanner and result stage
//   absorbs the extra result.
// Path: a byte's word event is written into the event queue at its transfer
//   and is loaded into the output register once that register is free.
// Reset (rst_n low, synchronous): scan state, queue and output register
//   clear; registers return to 6, 14, 0 and 16777216.
// Receiver stall: the output register holds its result; the queue fills and
//   in_chan.ready drops when it is full, with no result lost.
// Depends on pwe_pkg, pwe_if, pwe_front, pwe_queue and pwe_back.
`timescale 1ns / 1ps
`default_nettype none

module printable_word_extractor
  import pwe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  pwe_in_if.sink    in_chan,
  pwe_out_if.source out_chan,
  pwe_cfg_if.sink   cfg_chan
);

  cfg_t     cfg_r;
  word_ev_t ev;
  word_ev_t head;
  logic     ev_push;
  logic     q_pop;
  logic     q_empty;
  logic     q_full;

  // Register writes are always taken
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_len   <= MIN_LEN_RESET;
      cfg_r.max_len   <= MAX_LEN_RESET;
      cfg_r.strings   <= 1'b0;
      cfg_r.page_size <= PAGE_SIZE_RESET;
    end else if (cfg_chan.valid) begin
      case (cfg_reg_t'(cfg_chan.index))
        REG_MIN_LEN:   cfg_r.min_len   <= cfg_chan.data[LENGTH_BITS-1:0];
        REG_MAX_LEN:   cfg_r.max_len   <= cfg_chan.data[LENGTH_BITS-1:0];
        REG_STRINGS:   cfg_r.strings   <= cfg_chan.data[0];
        REG_PAGE_SIZE: cfg_r.page_size <= cfg_chan.data[OFFSET_BITS-1:0];
        default:       cfg_r           <= cfg_r;
      endcase
    end
  end

  pwe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_chan    (in_chan),
    .queue_full (q_full),
    .ev_push    (ev_push),
    .ev         (ev)
  );

  pwe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (ev_push),
    .push_data (ev),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  pwe_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .empty    (q_empty),
    .pop      (q_pop),
    .out_chan (out_chan)
  );

  // An inner span always closes the run of its byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.is_inner |-> out_chan.last_of_run)
    else $error("inner span not marked last");

  // A whole word with a pending inner span is followed by that span
  assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.ready && !out_chan.last_of_run |=>
      out_chan.valid && out_chan.is_inner)
    else $error("inner span missing after bracketed word");

  // No byte is taken while the event queue is full
  assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !ev_push)
    else $error("event pushed into full queue");

  // Output register is empty right after reset
  assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for printable_word_extractor: directed and random byte streams.
// It predicts every reported span in-line and checks each out_chan transfer against it.
// Depends on pwe_pkg, pwe_if and the printable_word_extractor top level.
`timescale 1ns / 1ps

module tb_top;
  import pwe_pkg::*;

  typedef struct {
    offset_t ofs;
    length_t len;
    logic    inner;
    logic    last;
  } span_t;

  localparam offset_t PAGE_MAX = '1;

  logic clk;
  logic rst_n;

  pwe_in_if  in_bus ();
  pwe_out_if out_bus ();
  pwe_cfg_if cfg_bus ();

  printable_word_extractor i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  // Register copies, at reset values
  length_t cur_min     = MIN_LEN_RESET;
  length_t cur_max     = MAX_LEN_RESET;
  logic    cur_strings = 1'b0;
  offset_t cur_page    = PAGE_SIZE_RESET;

  // Scan state copies
  offset_t scan_index   = '0;
  logic    scan_inside  = 1'b0;
  offset_t scan_start   = '0;
  run_t    scan_run     = '0;
  char_t   scan_first   = '0;
  char_t   scan_prev    = '0;
  logic    scan_stopped = 1'b0;

  span_t pending_spans[$];
  int    mismatches  = 0;
  int    live_bytes  = 0;
  int    hold_cycles = 0;
  bit    source_gaps = 1'b1;
  bit    sink_stalls = 1'b1;

  char_t openers[3] = '{CHAR_LPAREN, CHAR_LANGLE, CHAR_LBRACK};
  char_t closers[3] = '{CHAR_RPAREN, CHAR_RANGLE, CHAR_RBRACK};

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

  function automatic bit text_char(char_t c);
    return (c == CHAR_SPACE) ? cur_strings : (c >= 8'h21 && c <= 8'h7E);
  endfunction

  function automatic bit wrapped(char_t a, char_t b);
    bit r;
    r = 1'b0;
    if (a == CHAR_LPAREN) r = (b == CHAR_RPAREN);
    if (a == CHAR_LANGLE) r = (b == CHAR_RANGLE);
    if (a == CHAR_LBRACK) r = (b == CHAR_RBRACK);
    return r;
  endfunction

  // Advance the scan by one accepted byte and queue the spans it closes.
  // Returns 1 when the byte was swallowed by a stopped scan.
  function automatic bit track_byte(char_t c, logic bs);
    span_t s;
    bit    framed;
    if (bs) begin
      scan_index   = '0;
      scan_inside  = 1'b0;
      scan_start   = '0;
      scan_run     = '0;
      scan_first   = '0;
      scan_prev    = '0;
      scan_stopped = 1'b0;
    end
    if (scan_stopped) return 1'b1;
    if (!scan_inside) begin
      if (text_char(c)) begin
        scan_inside = 1'b1;
        scan_start  = scan_index;
        scan_run    = run_t'(1);
        scan_first  = c;
        scan_prev   = c;
      end
      // past the page: stop, even on a byte that opens a word
      if (scan_index > cur_page) begin
        scan_stopped = 1'b1;
        return 1'b0;
      end
    end else if (text_char(c)) begin
      if (scan_run != '1) scan_run++;
      scan_prev = c;
    end else begin
      if (cur_min <= scan_run && scan_run <= cur_max) begin
        framed  = (scan_run > 2) && wrapped(scan_first, scan_prev);
        s.ofs   = scan_start;
        s.len   = scan_run[LENGTH_BITS-1:0];
        s.inner = 1'b0;
        s.last  = !framed;
        pending_spans.insert(pending_spans.size(), s);
        if (framed) begin
          s.ofs   = scan_start + 1'b1;
          s.len   = scan_run[LENGTH_BITS-1:0] - 2'd2;
          s.inner = 1'b1;
          s.last  = 1'b1;
          pending_spans.insert(pending_spans.size(), s);
        end
      end
      scan_inside = 1'b0;
      scan_start  = '0;
      scan_run    = '0;
    end
    if (scan_index != '1) scan_index++;
    return 1'b0;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one byte; hold it until the transfer, then predict
  task automatic send_byte(char_t b, logic bs);
    int gap;
    gap = source_gaps ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.data_byte    <= b;
    in_bus.buffer_start <= bs;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (!track_byte(b, bs)) live_bytes++;
  endtask

  task automatic send_text(string s, logic bs_first);
    for (int i = 0; i < s.len(); i++) send_byte(char_t'(s[i]), bs_first && (i == 0));
  endtask

  // Drop valid, wait for every predicted span, then let the pipeline empty
  task automatic drain();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
    drain();
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      REG_MIN_LEN:   cur_min = val[LENGTH_BITS-1:0];
      REG_MAX_LEN:   cur_max = val[LENGTH_BITS-1:0];
      REG_STRINGS:   cur_strings = val[0];
      REG_PAGE_SIZE: cur_page = val[OFFSET_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic configure(int unsigned lo, int unsigned hi, bit spaces, int unsigned page);
    write_reg(REG_MIN_LEN, CFG_DATA_BITS'(lo));
    write_reg(REG_MAX_LEN, CFG_DATA_BITS'(hi));
    write_reg(REG_STRINGS, CFG_DATA_BITS'(spaces));
    write_reg(REG_PAGE_SIZE, CFG_DATA_BITS'(page));
  endtask

  function automatic char_t rand_text();
    if (cur_strings && $urandom_range(0, 9) == 0) return CHAR_SPACE;
    return char_t'($urandom_range(8'h21, 8'h7E));
  endfunction

  function automatic char_t rand_break();
    case ($urandom_range(0, 2))
      0:       return char_t'($urandom_range(0, 31));
      1:       return char_t'($urandom_range(8'h7F, 8'hFF));
      default: return cur_strings ? 8'h00 : CHAR_SPACE;
    endcase
  endfunction

  // Word length: mostly short, sometimes right at the length window edges
  function automatic int pick_len();
    int n;
    if ($urandom_range(0, 99) < 65) return $urandom_range(1, 18);
    case ($urandom_range(0, 3))
      0:       n = int'(cur_min) - 1;
      1:       n = int'(cur_min);
      2:       n = int'(cur_max);
      default: n = int'(cur_max) + 1;
    endcase
    if (n < 1) n = 1;
    if (n > 40) n = 40;
    return n;
  endfunction

  // One word with random content, sometimes framed, then a breaking byte
  task automatic send_random_word();
    int    len;
    int    k;
    bit    framed;
    char_t c;
    len    = pick_len();
    framed = (len >= 2) && ($urandom_range(0, 2) == 0);
    k      = $urandom_range(0, 2);
    for (int i = 0; i < len; i++) begin
      c = rand_text();
      if (framed && i == 0) c = openers[k];
      else if (framed && i == len - 1)
        c = ($urandom_range(0, 4) == 0) ? closers[$urandom_range(0, 2)] : closers[k];
      send_byte(c, 1'b0);
    end
    send_byte(rand_break(), 1'b0);
  endtask

  // Reset values: length window 6..14, framed words and byte extremes
  task automatic test_defaults();
    send_text("(abcd)", 1'b1);
    send_byte(CHAR_SPACE, 1'b0);
    send_text("<12345678>", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("~!!!!!", 1'b0);
    send_byte(8'h00, 1'b0);
    drain();
  endtask

  // Space as a word byte, full window, tiny framed words, then min above max
  task automatic test_strings_mode();
    configure(0, 65535, 1'b1, 32'(PAGE_SIZE_RESET));
    send_text("a b", 1'b1);
    send_byte(CHAR_DEL, 1'b0);
    send_text("()", 1'b0);
    send_byte(8'h80, 1'b0);
    send_text("[x]", 1'b0);
    send_byte(8'h1F, 1'b0);
    send_text("< >", 1'b0);
    send_byte(8'h00, 1'b0);
    configure(65535, 0, 1'b0, 32'(PAGE_SIZE_RESET));
    send_text("abcdefgh", 1'b0);
    send_byte(8'h00, 1'b0);
    drain();
  endtask

  // Page limit: a word crossing it survives, the next gap byte stops the scan
  task automatic test_page_limit();
    configure(1, 20, 1'b0, 3);
    send_byte(8'h00, 1'b1);
    send_text("abcdef", 1'b0);
    send_byte(CHAR_SPACE, 1'b0);
    send_byte(8'h01, 1'b0);
    send_text("xyz", 1'b0);
    send_byte(8'h00, 1'b0);
    send_text("qrs", 1'b1);
    send_byte(8'h00, 1'b0);
    // zero page: a word opening past it still stops the scan
    write_reg(REG_PAGE_SIZE, CFG_DATA_BITS'(0));
    send_byte(8'h00, 1'b1);
    send_text("zz", 1'b0);
    send_byte(8'h00, 1'b0);
    send_text("AB", 1'b1);
    send_byte(8'h00, 1'b0);
    // an open word is dropped by a buffer start
    write_reg(REG_PAGE_SIZE, PAGE_MAX);
    send_text("abc", 1'b1);
    send_text("wxyz", 1'b1);
    send_byte(8'h80, 1'b0);
    drain();
  endtask

  // Longest word in the window is reported, one byte longer is not
  task automatic test_long_words();
    configure(40, 40, 1'b0, 32'(PAGE_MAX));
    send_byte("a", 1'b1);
    repeat (39) send_byte("a", 1'b0);
    send_byte(8'h00, 1'b0);
    repeat (41) send_byte("b", 1'b0);
    send_byte(8'h0A, 1'b0);
    drain();
  endtask

  // Receiver holds off while framed words keep arriving: the input must stall
  task automatic test_backpressure();
    configure(6, 14, 1'b0, 32'(PAGE_SIZE_RESET));
    @(posedge clk);
    hold_cycles = 300;
    send_byte(8'h00, 1'b1);
    repeat (12) begin
      send_text("<abcdefg>", 1'b0);
      send_byte(8'h00, 1'b0);
    end
    drain();
  endtask

  // Random phases, each under its own register setting
  task automatic test_random();
    int unsigned lo;
    int          target;
    int          r;
    for (int p = 0; p < 6; p++) begin
      lo = $urandom_range(0, 8);
      case (p)
        0:       configure(0, 65535, 1'b1, 32'(PAGE_MAX));
        1:       configure(65535, 0, 1'b0, 32'(PAGE_MAX));
        default: configure(lo, lo + $urandom_range(0, 12), 1'($urandom_range(0, 1)),
                           $urandom_range(0, 1) ? $urandom_range(20, 400)
                                                : 32'(PAGE_SIZE_RESET));
      endcase
      source_gaps = (p != 2);
      sink_stalls = (p != 2) && (p != 4);
      target      = live_bytes + 40;
      send_byte(char_t'($urandom_range(0, 255)), 1'b1);
      while (live_bytes < target) begin
        r = $urandom_range(0, 99);
        if (r < 72)      send_random_word();
        else if (r < 92) send_byte(char_t'($urandom_range(0, 255)), 1'b0);
        else             send_byte(char_t'($urandom_range(0, 255)), 1'b1);
      end
    end
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
  endtask

  // Receiver: random stalls, plus the long hold-off when asked
  initial begin
    int stall;
    stall         = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_bus.ready <= 1'b0;
        hold_cycles--;
      end else if (stall > 0) begin
        out_bus.ready <= 1'b0;
        stall--;
      end else begin
        out_bus.ready <= 1'b1;
        if (sink_stalls) begin
          r_pick : begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 15)      stall = $urandom_range(1, 3);
            else if (r < 18) stall = $urandom_range(10, 40);
          end
        end
      end
    end
  end

  task automatic report_field(string name, longint unsigned want, longint unsigned got);
    mismatches++;
    $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
  endtask

  // Check each result transfer against the oldest predicted span
  always @(posedge clk) begin
    span_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_spans.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected span, expected none, got offset %0d length %0d", $time,
                 out_bus.word_offset, out_bus.word_length);
      end else begin
        want = pending_spans.pop_front();
        if (out_bus.word_offset !== want.ofs)
          report_field("word_offset", want.ofs, out_bus.word_offset);
        if (out_bus.word_length !== want.len)
          report_field("word_length", want.len, out_bus.word_length);
        if (out_bus.is_inner !== want.inner)
          report_field("is_inner", want.inner, out_bus.is_inner);
        if (out_bus.last_of_run !== want.last)
          report_field("last_of_run", want.last, out_bus.last_of_run);
      end
    end
  end

  // Test sequence
  initial begin
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.data_byte    = '0;
    in_bus.buffer_start = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = REG_MIN_LEN;
    cfg_bus.data        = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_defaults();
    test_strings_mode();
    test_page_limit();
    test_long_words();
    test_backpressure();
    test_random();
    drain();
    if (mismatches == 0 && pending_spans.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
